// File: design/rln_pkg.sv
// Package for the RGB L2 normalizer: field widths and default settings.
// Used by the channel interfaces, the top level and its checker.
package rln_pkg;

    localparam int CHAN_W        = 8;
    localparam int UNIT_W        = 16;
    localparam int SUM_W         = 18;
    localparam int FRAC_BITS_DEF = 15;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [UNIT_W-1:0] unit_t;

endpackage

// File: design/rln_if.sv
// Valid/ready channels for the RGB L2 normalizer: pixel input and unit output.
// Depends on rln_pkg for the field types.
interface rln_pixel_if;
    import rln_pkg::*;

    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rln_unit_if;
    import rln_pkg::*;

    logic  valid;
    logic  ready;
    unit_t red_unit;
    unit_t green_unit;
    unit_t blue_unit;
    logic  black_pixel;

    modport source (output valid, output red_unit, output green_unit, output blue_unit,
                    output black_pixel, input ready);
    modport sink (input valid, input red_unit, input green_unit, input blue_unit,
                  input black_pixel, output ready);
endinterface

// File: design/rgb_l2_normalizer.sv
// Throughput: one pixel per cycle while the output is not stalled;
// one setup stage, then one stage per quotient bit.
// A stall at the output holds every stage, bubbles included.
// Reset (rst_n, asynchronous, active low) clears all valid bits; data is not reset.
// Top level of the RGB L2 normalizer. Depends on rln_pkg and rln_if.sv.
module rgb_l2_normalizer #(
    parameter int FRAC_BITS = rln_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rln_pixel_if.sink  in,
    rln_unit_if.source out
);
    import rln_pkg::*;

    localparam int QW = FRAC_BITS + 1;
    localparam int NS = QW + 1;
    localparam int RW = 2 * CHAN_W + 2 * FRAC_BITS;
    localparam int EW = RW + 4;
    localparam int TW = QW + SUM_W;
    localparam int NL = 3;

    logic              v_reg    [NS];
    logic              blk_reg  [NS];
    logic [SUM_W-1:0]  s_reg    [NS];
    logic [RW-1:0]     r_reg    [NS][NL];
    logic [TW-1:0]     t_reg    [NS][NL];
    logic [QW-1:0]     q_reg    [NS][NL];

    logic [RW-1:0]     r_next   [NS][NL];
    logic [TW-1:0]     t_next   [NS][NL];
    logic [QW-1:0]     q_next   [NS][NL];
    logic [SUM_W-1:0]  s_next;
    logic [2*CHAN_W-1:0] sq     [NL];
    logic [EW-1:0]     term;
    logic              adv;
    int                k;

    assign adv      = !v_reg[NS-1] || out.ready;
    assign in.ready = adv;

    always_comb
    begin
        sq[0]  = in.red * in.red;
        sq[1]  = in.green * in.green;
        sq[2]  = in.blue * in.blue;
        s_next = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
        for (int l = 0; l < NL; l++)
        begin
            r_next[0][l] = RW'(sq[l]) << (2 * FRAC_BITS);
            t_next[0][l] = '0;
            q_next[0][l] = '0;
        end
        for (int i = 1; i < NS; i++)
        begin
            k = FRAC_BITS - (i - 1);
            for (int l = 0; l < NL; l++)
            begin
                term = (EW'(t_reg[i-1][l]) << (k + 1)) + (EW'(s_reg[i-1]) << (2 * k));
                if (term <= EW'(r_reg[i-1][l]))
                begin
                    r_next[i][l] = r_reg[i-1][l] - RW'(term);
                    t_next[i][l] = t_reg[i-1][l] + (TW'(s_reg[i-1]) << k);
                    q_next[i][l] = q_reg[i-1][l] | (QW'(1) << k);
                end
                else
                begin
                    r_next[i][l] = r_reg[i-1][l];
                    t_next[i][l] = t_reg[i-1][l];
                    q_next[i][l] = q_reg[i-1][l];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in.valid;
            for (int i = 1; i < NS; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg[0]   <= s_next;
            blk_reg[0] <= (s_next == '0);
            for (int l = 0; l < NL; l++)
            begin
                r_reg[0][l] <= r_next[0][l];
                t_reg[0][l] <= t_next[0][l];
                q_reg[0][l] <= q_next[0][l];
            end
            for (int i = 1; i < NS; i++)
            begin
                s_reg[i]   <= s_reg[i-1];
                blk_reg[i] <= blk_reg[i-1];
                for (int l = 0; l < NL; l++)
                begin
                    r_reg[i][l] <= r_next[i][l];
                    t_reg[i][l] <= t_next[i][l];
                    q_reg[i][l] <= q_next[i][l];
                end
            end
        end
    end

    assign out.valid       = v_reg[NS-1];
    assign out.black_pixel = blk_reg[NS-1];
    assign out.red_unit    = blk_reg[NS-1] ? '0 : UNIT_W'(q_reg[NS-1][0]);
    assign out.green_unit  = blk_reg[NS-1] ? '0 : UNIT_W'(q_reg[NS-1][1]);
    assign out.blue_unit   = blk_reg[NS-1] ? '0 : UNIT_W'(q_reg[NS-1][2]);

endmodule

// File: design/rln_checker.sv
// Port-level checker for the RGB L2 normalizer, attached by a bind statement.
// Depends on rln_pkg and on the rgb_l2_normalizer port names.
module rln_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input rln_pkg::unit_t       red_unit,
    input rln_pkg::unit_t       green_unit,
    input rln_pkg::unit_t       blue_unit,
    input logic                 black_pixel
);
    import rln_pkg::*;

    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && black_pixel |-> red_unit == '0 && green_unit == '0 && blue_unit == '0)
        else $error("black pixel beat carries nonzero units");

    a_lit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !black_pixel |-> (red_unit | green_unit | blue_unit) != '0)
        else $error("lit pixel beat has all units zero");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_unit) && $stable(black_pixel))
        else $error("stalled output beat changed");

endmodule

bind rgb_l2_normalizer rln_checker u_rln_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in.ready),
    .out_valid   (out.valid),
    .out_ready   (out.ready),
    .red_unit    (out.red_unit),
    .green_unit  (out.green_unit),
    .blue_unit   (out.blue_unit),
    .black_pixel (out.black_pixel)
);
